/* hw/rtl/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master register model package
// Types, register indexes, bit positions and bus event codes shared by the
// register model core and the top level.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [2:0] REG_CON    = 3'd0;
	localparam logic [2:0] REG_STAT   = 3'd1;
	localparam logic [2:0] REG_ADD    = 3'd2;
	localparam logic [2:0] REG_DS     = 3'd3;
	localparam logic [2:0] REG_BUSY   = 3'd4;
	localparam logic [2:0] REG_ENABLE = 3'd5;
	localparam logic [2:0] REG_INT    = 3'd6;
	localparam logic [2:0] REG_NONE   = 3'd7;

	localparam int CON_RESUME_BIT = 4;
	localparam int STAT_START_BIT = 5;
	localparam int STAT_NAK_BIT   = 0;
	localparam int STAT_MODE_LO   = 6;
	localparam logic [1:0] STAT_MODE_MRX = 2'b10;

	localparam int INT_BYTE_BIT = 0;
	localparam int INT_STOP_BIT = 1;

	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_START   = 3'd1;
	localparam logic [2:0] EV_RESTART = 3'd2;
	localparam logic [2:0] EV_WBYTE   = 3'd3;
	localparam logic [2:0] EV_RBYTE   = 3'd4;
	localparam logic [2:0] EV_STOP    = 3'd5;

	typedef struct packed {
		logic        opcode;
		logic [2:0]  reg_index;
		logic [31:0] write_data;
		logic        dev_present;
		logic        dev_ack;
		logic [7:0]  dev_read_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_level;
		logic [2:0]  bus_event;
		logic [6:0]  bus_address;
		logic        bus_read_dir;
		logic [7:0]  bus_byte;
	} result_t;

	typedef struct packed {
		logic [31:0] control;
		logic [31:0] status;
		logic [31:0] own_address;
		logic [7:0]  data_shift;
		logic [31:0] enable;
		logic [1:0]  pending_ints;
		logic        transfer_active;
		logic        receiving;
		logic        device_selected;
		logic        nak;
		logic [6:0]  cur_addr;
	} state_t;

endpackage

/* hw/rtl/i2cm_core.sv */
// ----------------------------------------------------------------------------
// I2C master register model core
// Combinational register access: computes the next register state and the
// result of one register transaction from the current state.
// ----------------------------------------------------------------------------
module i2cm_core
	import i2cm_pkg::*;
(
	input  state_t  state_cur,
	input  item_t   item,
	output state_t  state_nxt,
	output result_t result
);

	logic        was_started;
	logic        now_started;
	logic        byte_ok;
	logic [7:0]  rx_byte;
	logic [31:0] stat_read;

	always_comb begin
		state_nxt = state_cur;
		result = '0;
		was_started = state_cur.status[STAT_START_BIT];
		now_started = item.write_data[STAT_START_BIT];
		byte_ok = state_cur.device_selected && !state_cur.nak && item.dev_ack;
		rx_byte = byte_ok ? item.dev_read_byte : 8'd0;
		stat_read = state_cur.status;
		stat_read[STAT_NAK_BIT] = state_cur.nak;

		if (item.opcode == OP_READ) begin
			unique case (item.reg_index)
				REG_CON:    result.read_data = state_cur.control;
				REG_STAT:   result.read_data = stat_read;
				REG_ADD:    result.read_data = state_cur.own_address;
				REG_DS:     result.read_data = {24'd0, state_cur.data_shift};
				REG_ENABLE: result.read_data = state_cur.enable;
				REG_INT:    result.read_data = {30'd0, state_cur.pending_ints};
				REG_BUSY,
				REG_NONE:   result.read_data = '0;
				default:    result.read_data = '0;
			endcase
		end else begin
			unique case (item.reg_index)
				REG_CON: begin
					state_nxt.control = item.write_data;
					if (item.write_data[CON_RESUME_BIT] && state_cur.transfer_active) begin
						result.bus_address  = state_cur.cur_addr;
						result.bus_read_dir = state_cur.receiving;
						if (state_cur.receiving) begin
							if (!byte_ok) begin
								state_nxt.nak = 1'b1;
							end
							state_nxt.data_shift = rx_byte;
							result.bus_event = EV_RBYTE;
							result.bus_byte  = rx_byte;
						end else begin
							state_nxt.nak = !byte_ok;
							result.bus_event = EV_WBYTE;
							result.bus_byte  = state_cur.data_shift;
						end
						state_nxt.pending_ints[INT_BYTE_BIT] = 1'b1;
					end
				end
				REG_STAT: begin
					state_nxt.status = item.write_data;
					state_nxt.status[STAT_NAK_BIT] = 1'b0;
					if (!was_started && now_started) begin
						state_nxt.receiving =
							item.write_data[STAT_MODE_LO +: 2] == STAT_MODE_MRX;
						state_nxt.cur_addr = state_cur.data_shift[7:1];
						state_nxt.device_selected = item.dev_present;
						state_nxt.transfer_active = 1'b1;
						state_nxt.nak = !(item.dev_present && item.dev_ack);
						state_nxt.pending_ints[INT_BYTE_BIT] = 1'b1;
						result.bus_event = (state_cur.transfer_active &&
							state_cur.device_selected) ? EV_RESTART : EV_START;
						result.bus_address  = state_nxt.cur_addr;
						result.bus_read_dir = state_nxt.receiving;
					end else if (was_started && !now_started &&
						state_cur.transfer_active) begin
						result.bus_event    = EV_STOP;
						result.bus_address  = state_cur.cur_addr;
						result.bus_read_dir = state_cur.receiving;
						state_nxt.transfer_active = 1'b0;
						state_nxt.receiving = 1'b0;
						state_nxt.device_selected = 1'b0;
						state_nxt.pending_ints[INT_STOP_BIT] = 1'b1;
					end
				end
				REG_ADD:    state_nxt.own_address = item.write_data;
				REG_DS:     state_nxt.data_shift = item.write_data[7:0];
				REG_ENABLE: state_nxt.enable = item.write_data;
				REG_INT:    state_nxt.pending_ints =
					state_cur.pending_ints & ~item.write_data[1:0];
				REG_BUSY,
				REG_NONE: begin
				end
				default: begin
				end
			endcase
		end

		result.irq_level = |state_nxt.pending_ints;
	end

endmodule

/* hw/rtl/i2c_master_register_model.sv */
// ----------------------------------------------------------------------------
// I2C master register model
// Register-level model of a two-wire bus master controller with one result
// transaction for every register transaction.
// ----------------------------------------------------------------------------
// Each input transaction is captured in an input register and processed by the
// register logic, which places its result in a result register once that
// register is free or being emptied. One transaction is accepted every cycle as
// long as the result side keeps taking results. The input stage holds its
// transaction only while a result waits and the result side stalls. Bus
// transfers complete at once, so BUSY always reads zero.
module i2c_master_register_model
	import i2cm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [2:0]  reg_index,
	input  logic [31:0] write_data,
	input  logic        dev_present,
	input  logic        dev_ack,
	input  logic [7:0]  dev_read_byte,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] read_data,
	output logic        irq_level,
	output logic [2:0]  bus_event,
	output logic [6:0]  bus_address,
	output logic        bus_read_dir,
	output logic [7:0]  bus_byte
);

	item_t   item_s1;
	logic    valid_s1;
	result_t result_s2;
	logic    valid_s2;
	state_t  state_q;
	state_t  state_nxt;
	result_t result_nxt;
	logic    advance;
	logic    in_accept;

	assign advance   = valid_s1 && !(valid_s2 && out_stall);
	assign in_stall  = valid_s1 && valid_s2 && out_stall;
	assign in_accept = in_valid && !in_stall;

	i2cm_core u_core (
		.state_cur (state_q),
		.item      (item_s1),
		.state_nxt (state_nxt),
		.result    (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= '{opcode:        opcode,
			             reg_index:     reg_index,
			             write_data:    write_data,
			             dev_present:   dev_present,
			             dev_ack:       dev_ack,
			             dev_read_byte: dev_read_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_nxt;
		end
	end

	assign out_valid    = valid_s2;
	assign read_data    = result_s2.read_data;
	assign irq_level    = result_s2.irq_level;
	assign bus_event    = result_s2.bus_event;
	assign bus_address  = result_s2.bus_address;
	assign bus_read_dir = result_s2.bus_read_dir;
	assign bus_byte     = result_s2.bus_byte;

endmodule

/* tb/sv/i2cm_scoreboard_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register model scoreboard
// Predicts the result of every accepted register transaction from its own
// copy of the controller state and checks the block's results in order.
// ----------------------------------------------------------------------------
package i2cm_scoreboard_pkg;

	import i2cm_pkg::*;

	class i2cm_scoreboard;

		state_t  regs;
		result_t expected_results[$];
		int      errors;
		int      checked;
		int      starts;
		int      stops;
		int      bytes_written;
		int      bytes_read;

		function new();
			regs = '0;
			errors = 0;
			checked = 0;
			starts = 0;
			stops = 0;
			bytes_written = 0;
			bytes_read = 0;
		endfunction

		function void note_access(item_t acc);
			result_t r;
			logic    start_was;
			logic    start_now;
			r = '0;
			if (acc.opcode == OP_READ) begin
				case (acc.reg_index)
					REG_CON:    r.read_data = regs.control;
					REG_STAT: begin
						r.read_data = regs.status;
						r.read_data[STAT_NAK_BIT] = regs.nak;
					end
					REG_ADD:    r.read_data = regs.own_address;
					REG_DS:     r.read_data = {24'd0, regs.data_shift};
					REG_ENABLE: r.read_data = regs.enable;
					REG_INT:    r.read_data = {30'd0, regs.pending_ints};
					default:    r.read_data = '0;
				endcase
			end else begin
				case (acc.reg_index)
					REG_CON: begin
						regs.control = acc.write_data;
						if (acc.write_data[CON_RESUME_BIT] && regs.transfer_active) begin
							if (regs.receiving) begin
								if (regs.device_selected && !regs.nak && acc.dev_ack) begin
									regs.data_shift = acc.dev_read_byte;
								end else begin
									regs.data_shift = '0;
									regs.nak = 1'b1;
								end
								r.bus_event = EV_RBYTE;
							end else begin
								regs.nak = !(regs.device_selected && !regs.nak && acc.dev_ack);
								r.bus_event = EV_WBYTE;
							end
							r.bus_byte = regs.data_shift;
							r.bus_address = regs.cur_addr;
							r.bus_read_dir = regs.receiving;
							regs.pending_ints[INT_BYTE_BIT] = 1'b1;
						end
					end
					REG_STAT: begin
						start_was = regs.status[STAT_START_BIT];
						start_now = acc.write_data[STAT_START_BIT];
						regs.status = acc.write_data;
						regs.status[STAT_NAK_BIT] = 1'b0;
						if (!start_was && start_now) begin
							r.bus_event = (regs.transfer_active && regs.device_selected) ?
								EV_RESTART : EV_START;
							regs.receiving = acc.write_data[STAT_MODE_LO +: 2] == STAT_MODE_MRX;
							regs.cur_addr = regs.data_shift[7:1];
							regs.device_selected = acc.dev_present;
							regs.transfer_active = 1'b1;
							regs.nak = !(acc.dev_present && acc.dev_ack);
							regs.pending_ints[INT_BYTE_BIT] = 1'b1;
							r.bus_address = regs.cur_addr;
							r.bus_read_dir = regs.receiving;
						end else if (start_was && !start_now && regs.transfer_active) begin
							r.bus_event = EV_STOP;
							r.bus_address = regs.cur_addr;
							r.bus_read_dir = regs.receiving;
							regs.transfer_active = 1'b0;
							regs.receiving = 1'b0;
							regs.device_selected = 1'b0;
							regs.pending_ints[INT_STOP_BIT] = 1'b1;
						end
					end
					REG_ADD:    regs.own_address = acc.write_data;
					REG_DS:     regs.data_shift = acc.write_data[7:0];
					REG_ENABLE: regs.enable = acc.write_data;
					REG_INT:    regs.pending_ints = regs.pending_ints & ~acc.write_data[1:0];
					default: ;
				endcase
			end
			r.irq_level = |regs.pending_ints;
			expected_results.push_back(r);
		endfunction

		function void report_mismatch(string field, logic [31:0] want, logic [31:0] got);
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			errors++;
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual read_data %0h event %0d",
					$time, got.read_data, got.bus_event);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			checked++;
			case (want.bus_event)
				EV_START, EV_RESTART: starts++;
				EV_STOP:              stops++;
				EV_WBYTE:             bytes_written++;
				EV_RBYTE:             bytes_read++;
				default: ;
			endcase
			if (got.read_data !== want.read_data)
				report_mismatch("read_data", want.read_data, got.read_data);
			if (got.irq_level !== want.irq_level)
				report_mismatch("irq_level", 32'(want.irq_level), 32'(got.irq_level));
			if (got.bus_event !== want.bus_event)
				report_mismatch("bus_event", 32'(want.bus_event), 32'(got.bus_event));
			if (got.bus_address !== want.bus_address)
				report_mismatch("bus_address", 32'(want.bus_address), 32'(got.bus_address));
			if (got.bus_read_dir !== want.bus_read_dir)
				report_mismatch("bus_read_dir", 32'(want.bus_read_dir), 32'(got.bus_read_dir));
			if (got.bus_byte !== want.bus_byte)
				report_mismatch("bus_byte", 32'(want.bus_byte), 32'(got.bus_byte));
		endfunction

	endclass

endpackage

/* tb/sv/i2c_master_register_model_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register model testbench
// Drives directed and randomized register transactions, mostly well-formed
// start, byte and stop sequences, with random idling on both channels and one
// long result hold-off, and checks every result against a scoreboard.
// ----------------------------------------------------------------------------
module i2c_master_register_model_test;

	import i2cm_pkg::*;
	import i2cm_scoreboard_pkg::*;

	localparam int ITEM_TARGET = 2000;
	localparam int QUIET_TAIL  = 200;
	localparam int HOLDOFF     = 150;
	localparam int CYCLE_LIMIT = 200000;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        opcode = OP_READ;
	logic [2:0]  reg_index = REG_CON;
	logic [31:0] write_data = '0;
	logic        dev_present = 1'b0;
	logic        dev_ack = 1'b0;
	logic [7:0]  dev_read_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] read_data;
	logic        irq_level;
	logic [2:0]  bus_event;
	logic [6:0]  bus_address;
	logic        bus_read_dir;
	logic [7:0]  bus_byte;

	i2cm_scoreboard scoreboard;
	int             items_sent = 0;
	int             cycle_count = 0;
	bit             holdoff_done = 1'b0;

	i2c_master_register_model DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.reg_index(reg_index),
		.write_data(write_data),
		.dev_present(dev_present),
		.dev_ack(dev_ack),
		.dev_read_byte(dev_read_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_data(read_data),
		.irq_level(irq_level),
		.bus_event(bus_event),
		.bus_address(bus_address),
		.bus_read_dir(bus_read_dir),
		.bus_byte(bus_byte)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit idling_allowed();
		return items_sent < ITEM_TARGET - QUIET_TAIL;
	endfunction

	task automatic bus_access(input logic op, input logic [2:0] rg, input logic [31:0] d,
		input logic present, input logic ack, input logic [7:0] rbyte);
		if (idling_allowed() && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		reg_index <= rg;
		write_data <= d;
		dev_present <= present;
		dev_ack <= ack;
		dev_read_byte <= rbyte;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic access(input logic op, input logic [2:0] rg, input logic [31:0] d);
		bus_access(op, rg, d, $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0,
			8'($urandom));
	endtask

	task automatic random_transfer();
		logic [31:0] d;
		logic [1:0]  mode;
		logic        rx;
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 4))
				access(1'($urandom), 3'($urandom), $urandom);
			return;
		end
		rx = 1'($urandom);
		access(OP_WRITE, REG_DS, $urandom);
		d = $urandom;
		d[STAT_START_BIT] = 1'b1;
		mode = 2'($urandom_range(0, 2));
		if (mode == STAT_MODE_MRX)
			mode = 2'b11;
		d[STAT_MODE_LO +: 2] = rx ? STAT_MODE_MRX : mode;
		access(OP_WRITE, REG_STAT, d);
		repeat ($urandom_range(0, 6)) begin
			if (!rx)
				access(OP_WRITE, REG_DS, $urandom);
			d = $urandom;
			d[CON_RESUME_BIT] = $urandom_range(0, 7) != 0;
			access(OP_WRITE, REG_CON, d);
			case ($urandom_range(0, 3))
				0: access(OP_READ, REG_DS, $urandom);
				1: access(OP_READ, REG_STAT, $urandom);
				2: access(OP_READ, REG_INT, $urandom);
				default: access(OP_WRITE, REG_INT, $urandom);
			endcase
		end
		if ($urandom_range(0, 7) != 0) begin
			d = $urandom;
			d[STAT_START_BIT] = 1'b0;
			access(OP_WRITE, REG_STAT, d);
		end
		access(OP_READ, REG_INT, $urandom);
		if ($urandom_range(0, 1) == 0)
			access(OP_WRITE, REG_INT, 32'h3);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (arst_n && in_valid && !in_stall)
			scoreboard.note_access({opcode, reg_index, write_data, dev_present, dev_ack,
				dev_read_byte});
		if (arst_n && out_valid && !out_stall)
			scoreboard.check_result({read_data, irq_level, bus_event, bus_address,
				bus_read_dir, bus_byte});
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d transactions sent.", cycle_count,
				items_sent);
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		wait (arst_n);
		forever begin
			if (!idling_allowed()) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else if (!holdoff_done && items_sent >= 600) begin
				holdoff_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLDOFF) @(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				out_stall <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	initial begin
		scoreboard = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < 8; r++)
			access(OP_READ, 3'(r), 32'hFFFF_FFFF);
		access(OP_WRITE, REG_CON, 32'hFFFF_FFFF);
		access(OP_WRITE, REG_BUSY, 32'hFFFF_FFFF);
		access(OP_WRITE, REG_NONE, 32'hFFFF_FFFF);
		access(OP_WRITE, REG_ADD, 32'hFFFF_FFFF);
		access(OP_WRITE, REG_ENABLE, 32'hFFFF_FFFF);
		access(OP_WRITE, REG_DS, 32'hFFFF_FFFF);
		bus_access(OP_WRITE, REG_STAT, 32'hFFFF_FFFF, 1'b0, 1'b1, 8'h00);
		access(OP_READ, REG_STAT, 32'h0);
		bus_access(OP_WRITE, REG_CON, 32'h0000_0010, 1'b1, 1'b1, 8'hFF);
		access(OP_WRITE, REG_STAT, 32'hFFFF_FFFF);
		access(OP_WRITE, REG_STAT, 32'h0);
		access(OP_WRITE, REG_INT, 32'hFFFF_FFFF);
		access(OP_WRITE, REG_DS, 32'h0);
		bus_access(OP_WRITE, REG_STAT, 32'h0000_00A0, 1'b1, 1'b1, 8'h00);
		bus_access(OP_WRITE, REG_CON, 32'h0000_0010, 1'b1, 1'b1, 8'hFF);
		bus_access(OP_WRITE, REG_CON, 32'h0000_0010, 1'b1, 1'b0, 8'hAA);
		access(OP_READ, REG_DS, 32'h0);
		access(OP_WRITE, REG_STAT, 32'h0);

		while (items_sent < ITEM_TARGET)
			random_transfer();
		in_valid <= 1'b0;

		while (scoreboard.expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Checked %0d results from %0d register transactions.", scoreboard.checked,
			items_sent);
		$display("Bus activity: %0d starts, %0d stops, %0d bytes written, %0d bytes read.",
			scoreboard.starts, scoreboard.stops, scoreboard.bytes_written,
			scoreboard.bytes_read);
		if (scoreboard.errors == 0 && scoreboard.expected_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
